// File: sv/open_addressing_hash_table_unit_defines.svh
// Assertion macros shared by the hash table unit.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define OAHT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("oaht: same-cycle check failed");

// The condition holds in the cycle after the trigger.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("oaht: next-cycle check failed");

`endif

// File: sv/oaht_pkg.sv
// Package of types and constants for the open-addressing hash table unit.
package oaht_pkg;

	// Slot count must be a power of two; the start slot is the low hash bits.
	localparam int SLOTS      = 256;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 64;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int MARK_W = 2;
	localparam int WORD_W = MARK_W + KEY_BITS + VALUE_BITS;
	localparam int LIMIT_W = 9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

	// Stream field layout.
	localparam int OP_W        = 2;
	localparam int KEY_IN_W    = 32;
	localparam int HASH_W      = 32;
	localparam int VAL_IN_W    = 64;
	localparam int IN_KEY_LSB  = OP_W;
	localparam int IN_HASH_LSB = IN_KEY_LSB + KEY_IN_W;
	localparam int IN_VAL_LSB  = IN_HASH_LSB + HASH_W;
	localparam int IN_BITS     = IN_VAL_LSB + VAL_IN_W;
	localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int ST_W        = 2;
	localparam int VAL_OUT_W   = 64;
	localparam int OUT_BITS    = ST_W + 1 + VAL_OUT_W;
	localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_GET = 2'd0,
		OP_SET = 2'd1,
		OP_DEL = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [MARK_W-1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef struct packed {
		logic load;     // take a request and read its start slot
		logic step;     // move to the next slot and read it
		logic resolve;  // latch the probe outcome
		logic commit;   // write the table and load the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic skip;     // incoming request has an unknown operation
		logic stop;     // probe ends at the slot just read
		logic out_free; // result register can take a new result
	} ctrl_sts_t;

endpackage

// File: sv/open_addressing_hash_table_unit.sv
// Open-addressing key-value table with linear probing and tombstones. Each request
// carries an operation (get, set, delete), a key and its precomputed hash; the probe
// starts at the low hash bits and reads one slot per cycle from a registered-read slot
// memory, probing from 1 up to the slot count slots; an unknown operation skips
// the probe and is answered with a not-found status. The result register
// lets the next request in while a result waits. Set reuses the first tombstone on
// the probe path; a new key that would fill an empty slot once load_limit slots have
// been filled is refused with a full status. No clearing pass is needed after reset.
`include "open_addressing_hash_table_unit_defines.svh"

module open_addressing_hash_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// operation[1:0], key_id[33:2], key_hash[65:34], value_in[129:66], zero pad
	input  logic [oaht_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[1:0], new_key[2], value_out[66:3], zero pad
	output logic [oaht_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_wr_en,
	input  logic [oaht_pkg::LIMIT_W-1:0]   cfg_wr_data
);
	import oaht_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	oaht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	oaht_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Only one request is in flight at a time.
	`OAHT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// A committed result shows up on the output in the next cycle.
	`OAHT_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, m_tvalid)
	// A new key is only reported together with a done status.
	`OAHT_ASSERT_SAME(a_new_key_done, clk, arst_n, m_tvalid && m_tdata[2],
		m_tdata[1:0] == ST_DONE)
	// Commit never coincides with taking a new request.
	`OAHT_ASSERT_SAME(a_commit_excl, clk, arst_n, cmd.commit, !s_tready)

endmodule

// File: sv/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/oaht_datapath.sv
// Datapath of the hash table: slot memory, probe registers and result register.
module oaht_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [oaht_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [oaht_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_wr_en,
	input  logic [oaht_pkg::LIMIT_W-1:0]      cfg_wr_data,
	input  oaht_pkg::ctrl_cmd_t               cmd,
	output oaht_pkg::ctrl_sts_t               sts
);
	import oaht_pkg::*;

	// Request held for the duration of the probe.
	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               have_tomb_q;
	logic [IDX_W-1:0]   tomb_q;
	logic               found_q;
	logic [IDX_W-1:0]   place_q;
	logic               place_ok_q;
	logic               place_empty_q;
	logic [LIMIT_W-1:0] fill_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SLOTS-1:0]   valid_q;
	logic               vld_s1;
	logic               out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [IDX_W-1:0]  rd_addr;
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	mark_t                 cur_mark;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic                  is_found;
	logic                  is_empty;
	logic                  is_last;
	logic                  have_tomb_next;
	logic [IDX_W-1:0]      tomb_next;

	status_t              res_st;
	logic                 res_newk;
	logic [VAL_OUT_W-1:0] res_vout;
	logic                 res_fill;

	assign rd_en   = cmd.load | cmd.step;
	assign rd_addr = cmd.load ? s_tdata[IN_HASH_LSB +: IDX_W] : idx_q + 1'b1;

	oaht_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// A slot never written since reset reads as empty.
	assign cur_mark = vld_s1 ? mark_t'(rd_data[WORD_W-1 -: MARK_W]) : MARK_EMPTY;
	assign rd_key   = rd_data[VALUE_BITS +: KEY_BITS];
	assign rd_value = rd_data[VALUE_BITS-1:0];

	assign is_found = (cur_mark == MARK_LIVE) && (rd_key == key_q);
	assign is_empty = (cur_mark == MARK_EMPTY);
	assign is_last  = (cnt_q == CNT_W'(SLOTS - 1));
	assign have_tomb_next = have_tomb_q | (cur_mark == MARK_TOMB);
	assign tomb_next      = have_tomb_q ? tomb_q : idx_q;

	assign sts.stop     = is_found | is_empty | is_last;
	assign sts.skip     = !((s_tdata[OP_W-1:0] == OP_GET) || (s_tdata[OP_W-1:0] == OP_SET) ||
		(s_tdata[OP_W-1:0] == OP_DEL));
	assign sts.out_free = !out_valid_q | m_tready;

	// Outcome of the request, applied when the controller commits it.
	always_comb begin
		res_st   = ST_NOTFOUND;
		res_newk = 1'b0;
		res_vout = '0;
		res_fill = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = found_q ? idx_q : place_q;
		wr_data  = {MARK_LIVE, key_q, val_q};
		case (op_q)
			OP_GET: begin
				if (found_q) begin
					res_st   = ST_DONE;
					res_vout = VAL_OUT_W'(rd_value);
				end
			end
			OP_DEL: begin
				if (found_q) begin
					res_st  = ST_DONE;
					wr_en   = cmd.commit;
					wr_data = {MARK_TOMB, rd_key, rd_value};
				end
			end
			OP_SET: begin
				if (found_q) begin
					res_st = ST_DONE;
					wr_en  = cmd.commit;
				end else if (!place_ok_q) begin
					res_st = ST_FULL;
				end else if (place_empty_q && (fill_q >= limit_q)) begin
					res_st = ST_FULL;
				end else begin
					res_st   = ST_DONE;
					res_newk = 1'b1;
					res_fill = place_empty_q;
					wr_en    = cmd.commit;
				end
			end
			default: begin
				res_st = ST_NOTFOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tdata[OP_W-1:0];
			key_q <= s_tdata[IN_KEY_LSB +: KEY_BITS];
			val_q <= s_tdata[IN_VAL_LSB +: VALUE_BITS];
		end
		if (rd_en) begin
			vld_s1 <= valid_q[rd_addr];
		end
		if (cmd.load) begin
			idx_q       <= s_tdata[IN_HASH_LSB +: IDX_W];
			cnt_q       <= '0;
			have_tomb_q <= 1'b0;
		end else if (cmd.step || cmd.resolve) begin
			have_tomb_q <= have_tomb_next;
			tomb_q      <= tomb_next;
			if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.resolve) begin
			found_q       <= is_found;
			place_q       <= is_empty ? tomb_next : (have_tomb_next ? tomb_next : idx_q);
			place_ok_q    <= is_empty | have_tomb_next;
			place_empty_q <= is_empty & !have_tomb_q;
		end
		if (cmd.commit) begin
			out_data_q <= M_TDATA_W'({res_vout, res_newk, res_st});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			limit_q     <= LIMIT_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.commit && res_fill) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: sv/oaht_ctrl.sv
// Controller state machine that sequences accept, probe and commit.
module oaht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  oaht_pkg::ctrl_sts_t sts,
	output oaht_pkg::ctrl_cmd_t cmd
);
	import oaht_pkg::*;

	typedef enum logic [2:0] {
		IDLE   = 3'b001,
		CHECK  = 3'b010,
		FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next  = state_q;
		cmd         = '0;
		s_tready    = 1'b0;
		case (state_q)
			IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = sts.skip ? FINISH : CHECK;
				end
			end
			CHECK: begin
				if (sts.stop) begin
					cmd.resolve = 1'b1;
					state_next  = FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_next = IDLE;
				end
			end
			default: begin
				state_next = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
